>>> hw/rtl/mmdws_pkg.sv
// ----------------------------------------------------------------------------
// Memory map decoder package
// Transfer types, region and action codes, and wait-state tables.
// ----------------------------------------------------------------------------
package mmdws_pkg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] bus_address;
        logic [1:0]  access_size;
        logic        is_sequential;
        logic [31:0] wdata_in;
        logic        pc_in_bios;
        logic [16:0] obj_boundary;
    } t_req;

    typedef struct packed {
        logic [3:0]  target_region;
        logic [24:0] region_offset;
        logic [4:0]  access_cycles;
        logic [2:0]  action;
        logic [1:0]  write_size;
        logic [31:0] wdata_out;
    } t_rsp;

    typedef struct packed {
        logic [1:0]      sram_wait_sel;
        logic [2:0][1:0] rom_first_sel;
        logic [2:0]      rom_second_sel;
        logic [25:0]     cart_rom_bytes;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  nib;
        logic        wr;
        logic [1:0]  size;
        logic        seq;
        logic        pcb;
        logic        bios_ok;
        logic [16:0] objb;
        logic [24:0] off;
        logic [31:0] wd;
    } t_s1;

    typedef struct packed {
        logic [3:0]  nib;
        logic        wr;
        logic [1:0]  size;
        logic        seq;
        logic [3:0]  region;
        logic [24:0] off;
        logic [2:0]  act;
        logic [31:0] wd;
    } t_s2;

    // configuration register indexes
    localparam logic [2:0] CFG_SRAM_WAIT   = 3'd0;
    localparam logic [2:0] CFG_ROM0_FIRST  = 3'd1;
    localparam logic [2:0] CFG_ROM0_SECOND = 3'd2;
    localparam logic [2:0] CFG_ROM1_FIRST  = 3'd3;
    localparam logic [2:0] CFG_ROM1_SECOND = 3'd4;
    localparam logic [2:0] CFG_ROM2_FIRST  = 3'd5;
    localparam logic [2:0] CFG_ROM2_SECOND = 3'd6;
    localparam logic [2:0] CFG_CART_BYTES  = 3'd7;

    localparam logic [25:0] CART_BYTES_RST = 26'd33554432;

    // address nibble codes
    localparam logic [3:0] NIB_BIOS   = 4'd0;
    localparam logic [3:0] NIB_BWRAM  = 4'd2;
    localparam logic [3:0] NIB_CWRAM  = 4'd3;
    localparam logic [3:0] NIB_IO     = 4'd4;
    localparam logic [3:0] NIB_PAL    = 4'd5;
    localparam logic [3:0] NIB_VRAM   = 4'd6;
    localparam logic [3:0] NIB_OAM    = 4'd7;
    localparam logic [3:0] NIB_ROM0A  = 4'd8;
    localparam logic [3:0] NIB_ROM0B  = 4'd9;
    localparam logic [3:0] NIB_ROM1A  = 4'd10;
    localparam logic [3:0] NIB_ROM1B  = 4'd11;
    localparam logic [3:0] NIB_ROM2A  = 4'd12;
    localparam logic [3:0] NIB_ROM2B  = 4'd13;
    localparam logic [3:0] NIB_SRAM   = 4'd14;

    // target region codes
    localparam logic [3:0] REG_BIOS  = 4'd0;
    localparam logic [3:0] REG_BWRAM = 4'd1;
    localparam logic [3:0] REG_CWRAM = 4'd2;
    localparam logic [3:0] REG_IO    = 4'd3;
    localparam logic [3:0] REG_PAL   = 4'd4;
    localparam logic [3:0] REG_VRAM  = 4'd5;
    localparam logic [3:0] REG_OAM   = 4'd6;
    localparam logic [3:0] REG_ROM   = 4'd7;
    localparam logic [3:0] REG_NONE  = 4'd8;

    // action codes
    localparam logic [2:0] ACT_READ    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_LATCHED = 3'd2;
    localparam logic [2:0] ACT_OPEN    = 3'd3;
    localparam logic [2:0] ACT_DROP    = 3'd4;

    // access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_RSVD = 2'd3;

    localparam logic [16:0] VRAM_FOLD_START = 17'd98304;
    localparam logic [16:0] VRAM_FOLD_STEP  = 17'd32768;
    localparam logic [24:0] ROM_OFF_MASK    = 25'h1FF_FFFF;

    localparam logic [3:0] FIRST_WAIT [4] = '{4'd4, 4'd3, 4'd2, 4'd8};
    localparam logic [3:0] SECOND_WAIT [3][2] = '{
        '{4'd2, 4'd1},
        '{4'd4, 4'd1},
        '{4'd8, 4'd1}
    };

endpackage

>>> hw/rtl/mmdws_decode.sv
// ----------------------------------------------------------------------------
// Memory map decoder, stage 1
// Normalize the request, mask and mirror the offset per address nibble.
// ----------------------------------------------------------------------------
module mmdws_decode #(
    parameter int unsigned BIOS_BYTES       = 16384,
    parameter int unsigned BOARD_WRAM_BYTES = 262144,
    parameter int unsigned CHIP_WRAM_BYTES  = 32768,
    parameter int unsigned PALETTE_BYTES    = 1024,
    parameter int unsigned OAM_BYTES        = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mmdws_pkg::t_req   i_req,
    output logic              o_valid,
    output mmdws_pkg::t_s1    o_s1
);

    localparam logic [31:0] BIOS_LIMIT = 32'(BIOS_BYTES);
    localparam logic [24:0] BWRAM_MASK = 25'(BOARD_WRAM_BYTES - 1);
    localparam logic [24:0] CWRAM_MASK = 25'(CHIP_WRAM_BYTES - 1);
    localparam logic [24:0] PAL_MASK   = 25'(PALETTE_BYTES - 1);
    localparam logic [24:0] OAM_MASK   = 25'(OAM_BYTES - 1);

    logic           r_valid;
    mmdws_pkg::t_s1 r_s1;
    mmdws_pkg::t_s1 n_s1;
    logic [1:0]     size;
    logic           io_mirror;
    logic [16:0]    vram_off;
    logic [24:0]    low_addr;

    always_comb begin
        low_addr = i_req.bus_address[24:0];
        size     = (i_req.access_size == mmdws_pkg::SIZE_RSVD) ? mmdws_pkg::SIZE_WORD
                                                               : i_req.access_size;
        if (i_req.req_type && size == mmdws_pkg::SIZE_WORD) begin
            io_mirror = i_req.bus_address[11];
        end else begin
            io_mirror = (|i_req.bus_address[23:16]) | i_req.bus_address[11];
        end
        vram_off = i_req.bus_address[16:0];
        if (vram_off >= mmdws_pkg::VRAM_FOLD_START) begin
            vram_off = vram_off - mmdws_pkg::VRAM_FOLD_STEP;
        end

        n_s1.nib     = i_req.bus_address[27:24];
        n_s1.wr      = i_req.req_type;
        n_s1.size    = size;
        n_s1.seq     = i_req.is_sequential;
        n_s1.pcb     = i_req.pc_in_bios;
        n_s1.bios_ok = i_req.bus_address < BIOS_LIMIT;
        n_s1.objb    = i_req.obj_boundary;
        n_s1.wd      = i_req.wdata_in;

        case (n_s1.nib)
            mmdws_pkg::NIB_BIOS:  n_s1.off = low_addr;
            mmdws_pkg::NIB_BWRAM: n_s1.off = low_addr & BWRAM_MASK;
            mmdws_pkg::NIB_CWRAM: n_s1.off = low_addr & CWRAM_MASK;
            mmdws_pkg::NIB_IO: begin
                n_s1.off = {1'b0, io_mirror ? 8'h00 : i_req.bus_address[23:16],
                            i_req.bus_address[15:0]};
            end
            mmdws_pkg::NIB_PAL:   n_s1.off = low_addr & PAL_MASK;
            mmdws_pkg::NIB_VRAM:  n_s1.off = {8'h00, vram_off};
            mmdws_pkg::NIB_OAM:   n_s1.off = low_addr & OAM_MASK;
            mmdws_pkg::NIB_ROM0A, mmdws_pkg::NIB_ROM0B, mmdws_pkg::NIB_ROM1A,
            mmdws_pkg::NIB_ROM1B, mmdws_pkg::NIB_ROM2A, mmdws_pkg::NIB_ROM2B: begin
                n_s1.off = low_addr & mmdws_pkg::ROM_OFF_MASK;
            end
            default:              n_s1.off = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

>>> hw/rtl/mmdws_resolve.sv
// ----------------------------------------------------------------------------
// Memory map decoder, stage 2
// Run the range checks and settle the target region and action.
// ----------------------------------------------------------------------------
module mmdws_resolve (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mmdws_pkg::t_s1    i_s1,
    input  logic [25:0]       i_cart_rom_bytes,
    output logic              o_valid,
    output mmdws_pkg::t_s2    o_s2
);

    logic           r_valid;
    mmdws_pkg::t_s2 r_s2;
    mmdws_pkg::t_s2 n_s2;
    logic           byte_wr;
    logic [2:0]     act_hit;

    always_comb begin
        byte_wr = i_s1.wr && (i_s1.size == mmdws_pkg::SIZE_BYTE);
        act_hit = i_s1.wr ? mmdws_pkg::ACT_WRITE : mmdws_pkg::ACT_READ;

        n_s2.nib    = i_s1.nib;
        n_s2.wr     = i_s1.wr;
        n_s2.size   = i_s1.size;
        n_s2.seq    = i_s1.seq;
        n_s2.wd     = i_s1.wd;
        n_s2.region = mmdws_pkg::REG_NONE;
        n_s2.off    = '0;
        n_s2.act    = i_s1.wr ? mmdws_pkg::ACT_DROP : mmdws_pkg::ACT_OPEN;

        unique case (i_s1.nib) inside
            mmdws_pkg::NIB_BIOS: begin
                if (!i_s1.wr && i_s1.bios_ok) begin
                    n_s2.region = mmdws_pkg::REG_BIOS;
                    n_s2.off    = i_s1.off;
                    n_s2.act    = i_s1.pcb ? mmdws_pkg::ACT_READ : mmdws_pkg::ACT_LATCHED;
                end
            end
            mmdws_pkg::NIB_BWRAM: begin
                n_s2.region = mmdws_pkg::REG_BWRAM;
                n_s2.off    = i_s1.off;
                n_s2.act    = act_hit;
            end
            mmdws_pkg::NIB_CWRAM: begin
                n_s2.region = mmdws_pkg::REG_CWRAM;
                n_s2.off    = i_s1.off;
                n_s2.act    = act_hit;
            end
            mmdws_pkg::NIB_IO: begin
                n_s2.region = mmdws_pkg::REG_IO;
                n_s2.off    = i_s1.off;
                n_s2.act    = act_hit;
            end
            mmdws_pkg::NIB_PAL: begin
                n_s2.region = mmdws_pkg::REG_PAL;
                n_s2.off    = i_s1.off;
                n_s2.act    = act_hit;
            end
            mmdws_pkg::NIB_VRAM: begin
                if (!(byte_wr && i_s1.off[16:0] >= i_s1.objb)) begin
                    n_s2.region = mmdws_pkg::REG_VRAM;
                    n_s2.off    = i_s1.off;
                    n_s2.act    = act_hit;
                end
            end
            mmdws_pkg::NIB_OAM: begin
                if (!byte_wr) begin
                    n_s2.region = mmdws_pkg::REG_OAM;
                    n_s2.off    = i_s1.off;
                    n_s2.act    = act_hit;
                end
            end
            mmdws_pkg::NIB_ROM0A, mmdws_pkg::NIB_ROM0B, mmdws_pkg::NIB_ROM1A,
            mmdws_pkg::NIB_ROM1B, mmdws_pkg::NIB_ROM2A, mmdws_pkg::NIB_ROM2B: begin
                if (!byte_wr && ({1'b0, i_s1.off} < i_cart_rom_bytes)) begin
                    n_s2.region = mmdws_pkg::REG_ROM;
                    n_s2.off    = i_s1.off;
                    n_s2.act    = act_hit;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

>>> hw/rtl/mmdws_format.sv
// ----------------------------------------------------------------------------
// Memory map decoder, stage 3
// Look up the access cycles and shape the write size and data.
// ----------------------------------------------------------------------------
module mmdws_format (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mmdws_pkg::t_s2    i_s2,
    input  mmdws_pkg::t_cfg   i_cfg,
    output logic              o_valid,
    output mmdws_pkg::t_rsp   o_rsp
);

    logic            r_valid;
    mmdws_pkg::t_rsp r_rsp;
    mmdws_pkg::t_rsp n_rsp;
    logic            wide;
    logic [1:0]      win;
    logic [4:0]      n16;
    logic [4:0]      s16;
    logic [7:0]      wbyte;

    always_comb begin
        wide  = (i_s2.size == mmdws_pkg::SIZE_WORD);
        win   = i_s2.nib[2:1];
        n16   = '0;
        s16   = '0;
        wbyte = i_s2.wd[7:0];

        n_rsp.target_region = i_s2.region;
        n_rsp.region_offset = i_s2.off;
        n_rsp.action        = i_s2.act;
        n_rsp.write_size    = mmdws_pkg::SIZE_BYTE;
        n_rsp.wdata_out     = '0;

        case (i_s2.nib) inside
            mmdws_pkg::NIB_BWRAM: begin
                n_rsp.access_cycles = wide ? 5'd6 : 5'd3;
            end
            mmdws_pkg::NIB_VRAM, mmdws_pkg::NIB_OAM, mmdws_pkg::NIB_PAL: begin
                n_rsp.access_cycles = wide ? 5'd2 : 5'd1;
            end
            mmdws_pkg::NIB_ROM0A, mmdws_pkg::NIB_ROM0B, mmdws_pkg::NIB_ROM1A,
            mmdws_pkg::NIB_ROM1B, mmdws_pkg::NIB_ROM2A, mmdws_pkg::NIB_ROM2B: begin
                n16 = 5'd1 + 5'(mmdws_pkg::FIRST_WAIT[i_cfg.rom_first_sel[win]]);
                s16 = 5'd1 + 5'(mmdws_pkg::SECOND_WAIT[win][i_cfg.rom_second_sel[win]]);
                if (wide) begin
                    n_rsp.access_cycles = i_s2.seq ? s16 + s16 : n16 + s16;
                end else begin
                    n_rsp.access_cycles = i_s2.seq ? s16 : n16;
                end
            end
            mmdws_pkg::NIB_SRAM: begin
                n_rsp.access_cycles = 5'(mmdws_pkg::FIRST_WAIT[i_cfg.sram_wait_sel]);
            end
            default: n_rsp.access_cycles = 5'd1;
        endcase

        if (i_s2.act == mmdws_pkg::ACT_WRITE) begin
            if (i_s2.size == mmdws_pkg::SIZE_BYTE &&
                (i_s2.region == mmdws_pkg::REG_PAL || i_s2.region == mmdws_pkg::REG_VRAM)) begin
                n_rsp.region_offset = {i_s2.off[24:1], 1'b0};
                n_rsp.write_size    = mmdws_pkg::SIZE_HALF;
                n_rsp.wdata_out     = {16'h0000, wbyte, wbyte};
            end else begin
                n_rsp.write_size = i_s2.size;
                case (i_s2.size)
                    mmdws_pkg::SIZE_BYTE: n_rsp.wdata_out = {24'h000000, wbyte};
                    mmdws_pkg::SIZE_HALF: n_rsp.wdata_out = {16'h0000, i_s2.wd[15:0]};
                    default:              n_rsp.wdata_out = i_s2.wd;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

>>> hw/rtl/memory_map_decoder_with_waitstates_core.sv
// ----------------------------------------------------------------------------
// Memory map decoder with wait states
// Decodes one bus access into region, mirrored offset, cycles and action.
//
//   Channel  Signals                                    Direction
//   request  i_start, o_busy, i_req                     in
//   result   o_done, o_rsp                              out
//   config   i_cfg_valid, o_cfg_ready, i_cfg_index,     in
//            i_cfg_data
//
// Three register stages: decode, resolve, format. A start transfer passes
// through the decode, resolve and format registers to o_done; one access
// enters every cycle. o_busy stays low, so the pipeline never stalls. Reset
// clears the stage valid bits and loads the wait-state registers with
// setting zero and the full 32 MiB cartridge size.
// ----------------------------------------------------------------------------
module memory_map_decoder_with_waitstates_core #(
    parameter int unsigned BIOS_BYTES       = 16384,
    parameter int unsigned BOARD_WRAM_BYTES = 262144,
    parameter int unsigned CHIP_WRAM_BYTES  = 32768,
    parameter int unsigned PALETTE_BYTES    = 1024,
    parameter int unsigned OAM_BYTES        = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  mmdws_pkg::t_req   i_req,
    output logic              o_done,
    output mmdws_pkg::t_rsp   o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [25:0]       i_cfg_data
);

    mmdws_pkg::t_cfg r_cfg;
    logic            accept;
    logic            s1_valid;
    logic            s2_valid;
    mmdws_pkg::t_s1  s1;
    mmdws_pkg::t_s2  s2;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sram_wait_sel  <= '0;
            r_cfg.rom_first_sel  <= '0;
            r_cfg.rom_second_sel <= '0;
            r_cfg.cart_rom_bytes <= mmdws_pkg::CART_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mmdws_pkg::CFG_SRAM_WAIT:   r_cfg.sram_wait_sel     <= i_cfg_data[1:0];
                mmdws_pkg::CFG_ROM0_FIRST:  r_cfg.rom_first_sel[0]  <= i_cfg_data[1:0];
                mmdws_pkg::CFG_ROM0_SECOND: r_cfg.rom_second_sel[0] <= i_cfg_data[0];
                mmdws_pkg::CFG_ROM1_FIRST:  r_cfg.rom_first_sel[1]  <= i_cfg_data[1:0];
                mmdws_pkg::CFG_ROM1_SECOND: r_cfg.rom_second_sel[1] <= i_cfg_data[0];
                mmdws_pkg::CFG_ROM2_FIRST:  r_cfg.rom_first_sel[2]  <= i_cfg_data[1:0];
                mmdws_pkg::CFG_ROM2_SECOND: r_cfg.rom_second_sel[2] <= i_cfg_data[0];
                mmdws_pkg::CFG_CART_BYTES:  r_cfg.cart_rom_bytes    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mmdws_decode #(
        .BIOS_BYTES       (BIOS_BYTES),
        .BOARD_WRAM_BYTES (BOARD_WRAM_BYTES),
        .CHIP_WRAM_BYTES  (CHIP_WRAM_BYTES),
        .PALETTE_BYTES    (PALETTE_BYTES),
        .OAM_BYTES        (OAM_BYTES)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_req   (i_req),
        .o_valid (s1_valid),
        .o_s1    (s1)
    );

    mmdws_resolve u_resolve (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s1_valid),
        .i_s1             (s1),
        .i_cart_rom_bytes (r_cfg.cart_rom_bytes),
        .o_valid          (s2_valid),
        .o_s2             (s2)
    );

    mmdws_format u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_s2    (s2),
        .i_cfg   (r_cfg),
        .o_valid (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

>>> hw/rtl/mmdws_checker.sv
// ----------------------------------------------------------------------------
// Memory map decoder checker
// Port-level checks of latency and result field rules.
// ----------------------------------------------------------------------------
module mmdws_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input mmdws_pkg::t_rsp   o_rsp,
    input logic              o_done
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_done)
        else $error("transfer not answered after three cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy && i_rst_n, 3))
        else $error("result without a matching start transfer");

    a_idle_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.action != mmdws_pkg::ACT_WRITE) |->
        (o_rsp.write_size == mmdws_pkg::SIZE_BYTE && o_rsp.wdata_out == 32'h0))
        else $error("write fields set on a non-write result");

    a_miss_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.action == mmdws_pkg::ACT_OPEN ||
                    o_rsp.action == mmdws_pkg::ACT_DROP)) |->
        (o_rsp.target_region == mmdws_pkg::REG_NONE && o_rsp.region_offset == 25'h0))
        else $error("open bus or dropped write carries a region");

endmodule

bind memory_map_decoder_with_waitstates_core mmdws_checker u_mmdws_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_rsp   (o_rsp),
    .o_done  (o_done)
);

>>> verif/mmdws_decode_checker.sv
// ----------------------------------------------------------------------------
// Memory map decoder checker
// Watches the request, result and configuration channels of the decoder.
// Keeps a private copy of the wait-state registers, predicts the decode of
// every accepted transfer and compares each result in order, field by field.
// ----------------------------------------------------------------------------
module mmdws_decode_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  mmdws_pkg::t_req i_req,
    input  logic            i_done,
    input  mmdws_pkg::t_rsp i_rsp,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [25:0]     i_cfg_data,
    output int              o_mismatches,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BIOS_BYTES       = 16384;
    localparam int unsigned BOARD_WRAM_BYTES = 262144;
    localparam int unsigned CHIP_WRAM_BYTES  = 32768;
    localparam int unsigned PALETTE_BYTES    = 1024;
    localparam int unsigned OAM_BYTES        = 1024;

    localparam logic [16:0] VRAM_FOLD_AT   = 17'(96 * 1024);
    localparam logic [16:0] VRAM_FOLD_BY   = 17'(32 * 1024);
    localparam int unsigned MAX_REPORTS    = 40;

    localparam int unsigned NSEQ_WAIT_CYC [4]    = '{4, 3, 2, 8};
    localparam int unsigned SEQ_WAIT_CYC  [3][2] = '{'{2, 1}, '{4, 1}, '{8, 1}};

    logic [1:0]  sram_sel;
    logic [1:0]  rom_first_sel [3];
    logic [2:0]  rom_seq_sel;
    logic [25:0] cart_bytes;

    mmdws_pkg::t_rsp pending_decodes [$];
    mmdws_pkg::t_rsp want;

    function automatic logic [4:0] charged_cycles(logic [3:0] nib, logic wide, logic seq);
        int unsigned win;
        int unsigned n16;
        int unsigned s16;
        case (nib) inside
            mmdws_pkg::NIB_BWRAM: return wide ? 5'd6 : 5'd3;
            mmdws_pkg::NIB_PAL, mmdws_pkg::NIB_VRAM, mmdws_pkg::NIB_OAM:
                return wide ? 5'd2 : 5'd1;
            mmdws_pkg::NIB_ROM0A, mmdws_pkg::NIB_ROM0B, mmdws_pkg::NIB_ROM1A,
            mmdws_pkg::NIB_ROM1B, mmdws_pkg::NIB_ROM2A, mmdws_pkg::NIB_ROM2B: begin
                win = 32'((nib - mmdws_pkg::NIB_ROM0A) >> 1);
                n16 = 1 + NSEQ_WAIT_CYC[rom_first_sel[win]];
                s16 = 1 + SEQ_WAIT_CYC[win][rom_seq_sel[win]];
                if (wide) return seq ? 5'(2 * s16) : 5'(n16 + s16);
                return seq ? 5'(s16) : 5'(n16);
            end
            mmdws_pkg::NIB_SRAM: return 5'(NSEQ_WAIT_CYC[sram_sel]);
            default: return 5'd1;
        endcase
    endfunction

    function automatic mmdws_pkg::t_rsp decode_access(mmdws_pkg::t_req rq);
        mmdws_pkg::t_rsp r;
        logic [3:0]      nib;
        logic [1:0]      size;
        logic            wr;
        logic            mirror;
        logic [31:0]     a;
        logic [16:0]     vo;
        logic [24:0]     ro;
        nib  = rq.bus_address[27:24];
        size = (rq.access_size == mmdws_pkg::SIZE_RSVD) ? mmdws_pkg::SIZE_WORD
                                                         : rq.access_size;
        wr   = rq.req_type;
        a    = rq.bus_address;
        r    = '0;
        r.target_region = mmdws_pkg::REG_NONE;
        r.action        = wr ? mmdws_pkg::ACT_DROP : mmdws_pkg::ACT_OPEN;
        case (nib)
            mmdws_pkg::NIB_BIOS: begin
                if (!wr && a < BIOS_BYTES) begin
                    r.target_region = mmdws_pkg::REG_BIOS;
                    r.region_offset = a[24:0];
                    r.action        = rq.pc_in_bios ? mmdws_pkg::ACT_READ
                                                    : mmdws_pkg::ACT_LATCHED;
                end
            end
            mmdws_pkg::NIB_BWRAM: begin
                r.target_region = mmdws_pkg::REG_BWRAM;
                r.region_offset = 25'(a & (BOARD_WRAM_BYTES - 1));
                r.action        = wr ? mmdws_pkg::ACT_WRITE : mmdws_pkg::ACT_READ;
            end
            mmdws_pkg::NIB_CWRAM: begin
                r.target_region = mmdws_pkg::REG_CWRAM;
                r.region_offset = 25'(a & (CHIP_WRAM_BYTES - 1));
                r.action        = wr ? mmdws_pkg::ACT_WRITE : mmdws_pkg::ACT_READ;
            end
            mmdws_pkg::NIB_IO: begin
                mirror = (wr && size == mmdws_pkg::SIZE_WORD) ? a[11]
                                                              : ((|a[23:16]) || a[11]);
                if (mirror) a[23:16] = 8'h00;
                r.target_region = mmdws_pkg::REG_IO;
                r.region_offset = {1'b0, a[23:0]};
                r.action        = wr ? mmdws_pkg::ACT_WRITE : mmdws_pkg::ACT_READ;
            end
            mmdws_pkg::NIB_PAL: begin
                r.target_region = mmdws_pkg::REG_PAL;
                r.region_offset = 25'(a & (PALETTE_BYTES - 1));
                r.action        = wr ? mmdws_pkg::ACT_WRITE : mmdws_pkg::ACT_READ;
            end
            mmdws_pkg::NIB_VRAM: begin
                vo = a[16:0];
                if (vo >= VRAM_FOLD_AT) vo = vo - VRAM_FOLD_BY;
                r.target_region = mmdws_pkg::REG_VRAM;
                r.region_offset = {8'h00, vo};
                r.action        = wr ? mmdws_pkg::ACT_WRITE : mmdws_pkg::ACT_READ;
                if (wr && size == mmdws_pkg::SIZE_BYTE && vo >= rq.obj_boundary) begin
                    r.target_region = mmdws_pkg::REG_NONE;
                    r.region_offset = '0;
                    r.action        = mmdws_pkg::ACT_DROP;
                end
            end
            mmdws_pkg::NIB_OAM: begin
                if (!(wr && size == mmdws_pkg::SIZE_BYTE)) begin
                    r.target_region = mmdws_pkg::REG_OAM;
                    r.region_offset = 25'(a & (OAM_BYTES - 1));
                    r.action        = wr ? mmdws_pkg::ACT_WRITE : mmdws_pkg::ACT_READ;
                end
            end
            mmdws_pkg::NIB_ROM0A, mmdws_pkg::NIB_ROM0B, mmdws_pkg::NIB_ROM1A,
            mmdws_pkg::NIB_ROM1B, mmdws_pkg::NIB_ROM2A, mmdws_pkg::NIB_ROM2B: begin
                ro = a[24:0];
                if ({1'b0, ro} < cart_bytes && !(wr && size == mmdws_pkg::SIZE_BYTE)) begin
                    r.target_region = mmdws_pkg::REG_ROM;
                    r.region_offset = ro;
                    r.action        = wr ? mmdws_pkg::ACT_WRITE : mmdws_pkg::ACT_READ;
                end
            end
            default: ;
        endcase
        if (r.action == mmdws_pkg::ACT_WRITE) begin
            if (size == mmdws_pkg::SIZE_BYTE && (r.target_region == mmdws_pkg::REG_PAL ||
                                                 r.target_region == mmdws_pkg::REG_VRAM)) begin
                r.region_offset[0] = 1'b0;
                r.write_size       = mmdws_pkg::SIZE_HALF;
                r.wdata_out        = {16'h0000, rq.wdata_in[7:0], rq.wdata_in[7:0]};
            end else begin
                r.write_size = size;
                case (size)
                    mmdws_pkg::SIZE_BYTE: r.wdata_out = {24'h0, rq.wdata_in[7:0]};
                    mmdws_pkg::SIZE_HALF: r.wdata_out = {16'h0, rq.wdata_in[15:0]};
                    default:              r.wdata_out = rq.wdata_in;
                endcase
            end
        end
        r.access_cycles = charged_cycles(nib, size == mmdws_pkg::SIZE_WORD, rq.is_sequential);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        if (o_mismatches < MAX_REPORTS)
            $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, exp_val);
        o_mismatches++;
    endtask

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_decodes.delete();
            sram_sel      = '0;
            rom_first_sel = '{2'd0, 2'd0, 2'd0};
            rom_seq_sel   = '0;
            cart_bytes    = mmdws_pkg::CART_BYTES_RST;
        end else begin
            if (i_done) begin
                if (pending_decodes.size() == 0) begin
                    report_mismatch("result with no request outstanding",
                                    32'(i_rsp.region_offset), 32'h0);
                end else begin
                    want = pending_decodes.pop_front();
                    if (i_rsp.target_region !== want.target_region)
                        report_mismatch("target_region", 32'(i_rsp.target_region),
                                        32'(want.target_region));
                    if (i_rsp.region_offset !== want.region_offset)
                        report_mismatch("region_offset", 32'(i_rsp.region_offset),
                                        32'(want.region_offset));
                    if (i_rsp.access_cycles !== want.access_cycles)
                        report_mismatch("access_cycles", 32'(i_rsp.access_cycles),
                                        32'(want.access_cycles));
                    if (i_rsp.action !== want.action)
                        report_mismatch("action", 32'(i_rsp.action), 32'(want.action));
                    if (i_rsp.write_size !== want.write_size)
                        report_mismatch("write_size", 32'(i_rsp.write_size),
                                        32'(want.write_size));
                    if (i_rsp.wdata_out !== want.wdata_out)
                        report_mismatch("wdata_out", i_rsp.wdata_out, want.wdata_out);
                end
            end
            if (i_start && !i_busy)
                pending_decodes.push_back(decode_access(i_req));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mmdws_pkg::CFG_SRAM_WAIT:   sram_sel         = i_cfg_data[1:0];
                    mmdws_pkg::CFG_ROM0_FIRST:  rom_first_sel[0] = i_cfg_data[1:0];
                    mmdws_pkg::CFG_ROM0_SECOND: rom_seq_sel[0]   = i_cfg_data[0];
                    mmdws_pkg::CFG_ROM1_FIRST:  rom_first_sel[1] = i_cfg_data[1:0];
                    mmdws_pkg::CFG_ROM1_SECOND: rom_seq_sel[1]   = i_cfg_data[0];
                    mmdws_pkg::CFG_ROM2_FIRST:  rom_first_sel[2] = i_cfg_data[1:0];
                    mmdws_pkg::CFG_ROM2_SECOND: rom_seq_sel[2]   = i_cfg_data[0];
                    mmdws_pkg::CFG_CART_BYTES:  cart_bytes       = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = pending_decodes.size();
    end

endmodule

>>> verif/memory_map_decoder_with_waitstates_core_tb.sv
// ----------------------------------------------------------------------------
// Memory map decoder testbench
// Drives directed accesses covering every region and corner of the decode,
// then random accesses over several wait-state and cartridge-size settings,
// with random gaps between transfers in most phases. The checker beside the
// decoder predicts and compares every result; this module reports the verdict.
// ----------------------------------------------------------------------------
module memory_map_decoder_with_waitstates_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic RD = 1'b0;
    localparam logic WR = 1'b1;
    localparam logic [1:0] SZ_BYTE = mmdws_pkg::SIZE_BYTE;
    localparam logic [1:0] SZ_HALF = mmdws_pkg::SIZE_HALF;
    localparam logic [1:0] SZ_WORD = mmdws_pkg::SIZE_WORD;
    localparam logic [1:0] SZ_RSVD = mmdws_pkg::SIZE_RSVD;
    localparam int   ITEMS_PER_PHASE = 140;
    localparam int   NUM_PHASES      = 7;
    localparam int   DRAIN_CYCLES    = 5;

    logic            i_clk;
    logic            i_rst_n     = 1'b0;
    logic            i_start     = 1'b0;
    mmdws_pkg::t_req i_req       = '0;
    logic            i_cfg_valid = 1'b0;
    logic [2:0]      i_cfg_index = mmdws_pkg::CFG_SRAM_WAIT;
    logic [25:0]     i_cfg_data  = '0;
    logic            o_busy;
    logic            o_done;
    mmdws_pkg::t_rsp o_rsp;
    logic            o_cfg_ready;
    int              mismatches;
    int              pending;

    int          max_gap;
    logic [25:0] cart_size;

    memory_map_decoder_with_waitstates_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mmdws_decode_checker decode_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic mmdws_pkg::t_req mk_access(logic wr, logic [31:0] addr,
                                                  logic [1:0] size, logic seq,
                                                  logic [31:0] wd, logic pcb,
                                                  logic [16:0] objb);
        mmdws_pkg::t_req rq;
        rq.req_type      = wr;
        rq.bus_address   = addr;
        rq.access_size   = size;
        rq.is_sequential = seq;
        rq.wdata_in      = wd;
        rq.pc_in_bios    = pcb;
        rq.obj_boundary  = objb;
        return rq;
    endfunction

    function automatic mmdws_pkg::t_req random_access();
        mmdws_pkg::t_req rq;
        logic [31:0]     a;
        logic [3:0]      nib;
        rq.req_type      = 1'($urandom_range(0, 1));
        rq.access_size   = 2'($urandom_range(0, 3));
        rq.is_sequential = 1'($urandom_range(0, 1));
        rq.wdata_in      = $urandom;
        rq.pc_in_bios    = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       rq.obj_boundary = '0;
            1:       rq.obj_boundary = '1;
            default: rq.obj_boundary = 17'($urandom);
        endcase
        a = $urandom;
        if ($urandom_range(0, 7) != 0) begin
            nib = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 3) != 0) a[31:28] = 4'h0;
            a[27:24] = nib;
            if (nib == mmdws_pkg::NIB_BIOS && $urandom_range(0, 1) == 1)
                a = 32'($urandom_range(0, 16400));
            if (nib == mmdws_pkg::NIB_IO) begin
                if ($urandom_range(0, 1) == 1) a[23:16] = 8'h00;
                if ($urandom_range(0, 1) == 1) a[11] = 1'b0;
            end
            if (nib >= mmdws_pkg::NIB_ROM0A && nib <= mmdws_pkg::NIB_ROM2B &&
                $urandom_range(0, 1) == 1)
                a[24:0] = 25'(cart_size) + 25'($urandom_range(0, 7)) - 25'd4;
        end
        rq.bus_address = a;
        return rq;
    endfunction

    task automatic send_access(mmdws_pkg::t_req rq);
        int gap;
        i_start <= 1'b1;
        i_req   <= rq;
        do @(posedge i_clk); while (o_busy);
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [25:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_waits(logic [1:0] sram, logic [1:0] r0f, logic r0s,
                                 logic [1:0] r1f, logic r1s, logic [1:0] r2f,
                                 logic r2s, logic [25:0] cart);
        write_reg(mmdws_pkg::CFG_SRAM_WAIT,   26'(sram));
        write_reg(mmdws_pkg::CFG_ROM0_FIRST,  26'(r0f));
        write_reg(mmdws_pkg::CFG_ROM0_SECOND, 26'(r0s));
        write_reg(mmdws_pkg::CFG_ROM1_FIRST,  26'(r1f));
        write_reg(mmdws_pkg::CFG_ROM1_SECOND, 26'(r1s));
        write_reg(mmdws_pkg::CFG_ROM2_FIRST,  26'(r2f));
        write_reg(mmdws_pkg::CFG_ROM2_SECOND, 26'(r2s));
        write_reg(mmdws_pkg::CFG_CART_BYTES,  cart);
        i_cfg_valid <= 1'b0;
        cart_size = cart;
        @(posedge i_clk);
    endtask

    initial begin
        max_gap   = 3;
        cart_size = mmdws_pkg::CART_BYTES_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_access(mk_access(RD, 32'h0000_0000, SZ_WORD, 1'b0, 32'h0, 1'b1, 17'h0));
        send_access(mk_access(RD, 32'h0000_3FFE, SZ_HALF, 1'b1, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(RD, 32'h0000_4000, SZ_BYTE, 1'b0, 32'h0, 1'b1, 17'h0));
        send_access(mk_access(WR, 32'h0000_0010, SZ_WORD, 1'b0, 32'hFFFF_FFFF, 1'b1, 17'h0));
        send_access(mk_access(RD, 32'hF000_0000, SZ_WORD, 1'b1, 32'h0, 1'b1, 17'h0));
        send_access(mk_access(RD, 32'h0100_0000, SZ_HALF, 1'b0, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h0E00_1234, SZ_BYTE, 1'b1, 32'h0000_005A, 1'b0, 17'h0));
        send_access(mk_access(RD, 32'hFF00_0000, SZ_WORD, 1'b0, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h02FF_FFFF, SZ_WORD, 1'b0, 32'hDEAD_BEEF, 1'b0, 17'h0));
        send_access(mk_access(RD, 32'h0300_7FFF, SZ_RSVD, 1'b1, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(RD, 32'h0412_0800, SZ_BYTE, 1'b0, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h04FF_0800, SZ_WORD, 1'b0, 32'h1234_5678, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h04FF_0000, SZ_WORD, 1'b1, 32'h8765_4321, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h0401_0000, SZ_HALF, 1'b0, 32'hFFFF_ABCD, 1'b0, 17'h0));
        send_access(mk_access(RD, 32'h0400_0000, SZ_HALF, 1'b0, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h0500_03FF, SZ_BYTE, 1'b0, 32'h1234_56A5, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h0601_8001, SZ_BYTE, 1'b0, 32'h0000_00C3, 1'b0, 17'h1FFFF));
        send_access(mk_access(WR, 32'h0601_0000, SZ_BYTE, 1'b1, 32'h0000_0077, 1'b0, 17'h10000));
        send_access(mk_access(RD, 32'h0601_FFFF, SZ_WORD, 1'b1, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h0700_0001, SZ_BYTE, 1'b0, 32'h0000_0011, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h0700_03FC, SZ_WORD, 1'b0, 32'hCAFE_F00D, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h0800_0000, SZ_BYTE, 1'b0, 32'h0000_0022, 1'b0, 17'h0));
        send_access(mk_access(RD, 32'h09FF_FFFF, SZ_HALF, 1'b1, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(RD, 32'h0B00_0100, SZ_WORD, 1'b0, 32'h0, 1'b0, 17'h0));
        send_access(mk_access(WR, 32'h0D00_0002, SZ_HALF, 1'b1, 32'h0BAD_5EED, 1'b0, 17'h0));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: ;
                1: program_waits(2'd3, 2'd3, 1'b1, 2'd3, 1'b1, 2'd3, 1'b1,
                                 mmdws_pkg::CART_BYTES_RST);
                2: program_waits(2'd0, 2'd0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0, 26'd0);
                3: program_waits(2'd1, 2'd2, 1'b1, 2'd1, 1'b0, 2'd2, 1'b1,
                                 26'($urandom_range(0, 33554432)));
                default:
                    program_waits(2'($urandom), 2'($urandom), 1'($urandom),
                                  2'($urandom), 1'($urandom), 2'($urandom),
                                  1'($urandom),
                                  ($urandom_range(0, 1) == 1) ?
                                      26'($urandom_range(0, 4096)) :
                                      26'($urandom_range(0, 33554432)));
            endcase
            max_gap = (phase % 3 == 1) ? 0 : 6;
            repeat (ITEMS_PER_PHASE) send_access(random_access());
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
